[src/bdc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared types and constants for the button debounce and click detector.
// ----------------------------------------------------------------------------
package bdc_pkg;

    localparam int FIELD_W     = 3;
    localparam int SAMPLES_W   = 8;
    localparam int TICKS_W     = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [SAMPLES_W-1:0] SAMPLES_RESET = 8'd8;
    localparam logic [TICKS_W-1:0]   TICKS_RESET   = 16'd250;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEBOUNCE_SAMPLES   = 2'd0,
        CFG_DOUBLE_CLICK_TICKS = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [SAMPLES_W-1:0] debounce_samples;
        logic [TICKS_W-1:0]   double_click_ticks;
    } cfg_t;

    typedef struct packed {
        logic pressed;
        logic click;
        logic double_click;
    } button_status_t;

endpackage : bdc_pkg
`default_nettype wire

[src/bdc_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdc_if
// Valid/ready channel interfaces: raw samples, results and config writes.
// ----------------------------------------------------------------------------
interface bdc_sample_if;
    logic                       valid;
    logic                       ready;
    logic [bdc_pkg::FIELD_W-1:0] raw_levels;

    modport source (output valid, output raw_levels, input ready);
    modport sink   (input valid, input raw_levels, output ready);
endinterface : bdc_sample_if

interface bdc_result_if;
    logic                       valid;
    logic                       ready;
    logic [bdc_pkg::FIELD_W-1:0] pressed_levels;
    logic [bdc_pkg::FIELD_W-1:0] click_events;
    logic [bdc_pkg::FIELD_W-1:0] double_click_events;

    modport source (output valid, output pressed_levels, output click_events,
                    output double_click_events, input ready);
    modport sink   (input valid, input pressed_levels, input click_events,
                    input double_click_events, output ready);
endinterface : bdc_result_if

interface bdc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bdc_pkg::CFG_INDEX_W-1:0] index;
    logic [bdc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : bdc_cfg_if
`default_nettype wire

[src/bdc_button.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdc_button
// Per-button integrating debouncer with single/double click window.
// ----------------------------------------------------------------------------
module bdc_button (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic                level_high,
    input  wire bdc_pkg::cfg_t       cfg,
    output bdc_pkg::button_status_t  status
);
    import bdc_pkg::*;

    logic [SAMPLES_W-1:0] count_reg, count_next;
    logic                 released_reg, released_next;
    logic [TICKS_W-1:0]   window_reg, window_next;
    logic [TICKS_W-1:0]   window_dec;
    logic [SAMPLES_W:0]   count_inc;

    always_comb
    begin
        window_dec    = (window_reg != '0) ? window_reg - 1'b1 : '0;
        count_inc     = {1'b0, count_reg} + 1'b1;
        count_next    = count_reg;
        released_next = released_reg;
        window_next   = window_dec;
        status        = '0;
        if (level_high)
        begin
            if (count_inc >= {1'b0, cfg.debounce_samples})
            begin
                count_next    = cfg.debounce_samples;
                released_next = 1'b1;
            end
            else
            begin
                count_next = count_inc[SAMPLES_W-1:0];
            end
        end
        else if (count_reg <= SAMPLES_W'(1))
        begin
            count_next = '0;
            if (released_reg)
            begin
                released_next = 1'b0;
                if (window_dec != '0)
                begin
                    window_next         = '0;
                    status.double_click = 1'b1;
                end
                else
                begin
                    window_next  = cfg.double_click_ticks;
                    status.click = 1'b1;
                end
            end
        end
        else
        begin
            count_next = count_reg - 1'b1;
        end
        status.pressed = ~released_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= SAMPLES_RESET;
            released_reg <= 1'b1;
            window_reg   <= '0;
        end
        else if (step)
        begin
            count_reg    <= count_next;
            released_reg <= released_next;
            window_reg   <= window_next;
        end
    end

endmodule : bdc_button
`default_nettype wire

[src/button_debounce_click_detector.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_click_detector
// Integrating debouncer with single and double click detection per button.
//
// Usage:
//   samples : one transaction per sampling tick, raw_levels bit i = button i,
//             1 means released.
//   result  : one transaction per sample: debounced pressed_levels plus
//             one-tick click_events and double_click_events.
//   cfg     : register writes (0 debounce_samples, 1 double_click_ticks),
//             always ready; write only while no sample is in flight.
// A result is valid in the cycle after its sample is taken; one sample per
// cycle is sustained while result.ready stays high, set by the single result
// register that holds the outcome of the per-button counter update.
// A stalled result keeps its register; the next sample is taken in the same
// cycle the waiting result leaves, so samples backpressure only while the
// result register is full and not being taken.
// Reset: registers return to 8 and 250, every button reads fully released,
// no double-click window is open, and the result register is empty.
// ----------------------------------------------------------------------------
module button_debounce_click_detector #(
    parameter int NUM_BUTTONS = 3
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bdc_sample_if.sink  samples,
    bdc_result_if.source result,
    bdc_cfg_if.sink     cfg
);
    import bdc_pkg::*;

    cfg_t                 cfg_reg;
    logic                 out_valid_reg;
    logic [FIELD_W-1:0]   pressed_reg, click_reg, double_reg;
    logic [FIELD_W-1:0]   pressed_next, click_next, double_next;
    logic                 step;
    button_status_t       status [NUM_BUTTONS];

    assign cfg.ready     = 1'b1;
    assign samples.ready = ~out_valid_reg | result.ready;
    assign step          = samples.valid & samples.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_samples   <= SAMPLES_RESET;
            cfg_reg.double_click_ticks <= TICKS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_DEBOUNCE_SAMPLES:
                    cfg_reg.debounce_samples <= cfg.data[SAMPLES_W-1:0];
                CFG_DOUBLE_CLICK_TICKS:
                    cfg_reg.double_click_ticks <= cfg.data[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_button
        logic level_high;
        if (i < FIELD_W)
        begin : g_pin
            assign level_high = samples.raw_levels[i];
        end
        else
        begin : g_nopin
            assign level_high = 1'b0;
        end
        bdc_button u_button (
            .clk        (clk),
            .rst_n      (rst_n),
            .step       (step),
            .level_high (level_high),
            .cfg        (cfg_reg),
            .status     (status[i])
        );
    end

    for (genvar b = 0; b < FIELD_W; b++)
    begin : g_field
        if (b < NUM_BUTTONS)
        begin : g_used
            assign pressed_next[b] = status[b].pressed;
            assign click_next[b]   = status[b].click;
            assign double_next[b]  = status[b].double_click;
        end
        else
        begin : g_unused
            assign pressed_next[b] = 1'b0;
            assign click_next[b]   = 1'b0;
            assign double_next[b]  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            out_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            pressed_reg <= pressed_next;
            click_reg   <= click_next;
            double_reg  <= double_next;
        end
    end

    assign result.valid               = out_valid_reg;
    assign result.pressed_levels      = pressed_reg;
    assign result.click_events        = click_reg;
    assign result.double_click_events = double_reg;

endmodule : button_debounce_click_detector
`default_nettype wire

[bench/tb_button_debounce_click_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_click_detector
// Self-checking bench for the three-button debouncer and click detector.
// Each raw-level transaction is run through a local per-button model of the
// integrating counter and double-click window. The resulting pressed/click/
// double-click transaction is queued and compared in order with the block's
// output. Stimulus covers directed press sequences under several register
// settings, then bounce-laden random button activity. Random stalls are
// applied on both channels, plus one long output hold-off.
// ----------------------------------------------------------------------------
module tb_button_debounce_click_detector;
    import bdc_pkg::*;

    typedef struct packed {
        logic [FIELD_W-1:0] pressed;
        logic [FIELD_W-1:0] clicks;
        logic [FIELD_W-1:0] dbls;
    } tick_result_t;

    class click_scoreboard;
        logic [SAMPLES_W:0]   integ [FIELD_W];
        logic                 released [FIELD_W];
        logic [TICKS_W-1:0]   window [FIELD_W];
        logic [SAMPLES_W-1:0] samples_cfg;
        logic [TICKS_W-1:0]   ticks_cfg;
        tick_result_t         expected_ticks [$];
        int                   fails;

        function new();
            samples_cfg = SAMPLES_RESET;
            ticks_cfg   = TICKS_RESET;
            for (int b = 0; b < FIELD_W; b++)
            begin
                integ[b]    = {1'b0, SAMPLES_RESET};
                released[b] = 1'b1;
                window[b]   = '0;
            end
            fails = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_DEBOUNCE_SAMPLES)
                samples_cfg = data[SAMPLES_W-1:0];
            else if (idx == CFG_DOUBLE_CLICK_TICKS)
                ticks_cfg = data[TICKS_W-1:0];
        endfunction

        function void note_sample(logic [FIELD_W-1:0] raw);
            tick_result_t want;
            logic [SAMPLES_W:0] nxt;
            want = '0;
            for (int b = 0; b < FIELD_W; b++)
            begin
                if (window[b] != 0)
                    window[b]--;
                if (raw[b])
                begin
                    nxt = integ[b] + 1'b1;
                    if (nxt >= {1'b0, samples_cfg})
                    begin
                        integ[b]    = {1'b0, samples_cfg};
                        released[b] = 1'b1;
                    end
                    else
                        integ[b] = nxt;
                end
                else if (integ[b] <= 1)
                begin
                    integ[b] = '0;
                    if (released[b])
                    begin
                        released[b] = 1'b0;
                        if (window[b] != 0)
                        begin
                            window[b]    = '0;
                            want.dbls[b] = 1'b1;
                        end
                        else
                        begin
                            window[b]      = ticks_cfg;
                            want.clicks[b] = 1'b1;
                        end
                    end
                end
                else
                    integ[b]--;
                want.pressed[b] = !released[b];
            end
            expected_ticks.push_back(want);
        endfunction

        function void log_fail(string why, tick_result_t want, tick_result_t got);
            fails++;
            if (fails <= 10)
                $display("%0t: %s: want pressed=%b click=%b dbl=%b, got pressed=%b click=%b dbl=%b",
                         $realtime, why, want.pressed, want.clicks, want.dbls,
                         got.pressed, got.clicks, got.dbls);
        endfunction

        function void check_result(tick_result_t got);
            tick_result_t want;
            if (expected_ticks.size() == 0)
            begin
                log_fail("unexpected transaction", 'x, got);
                return;
            end
            want = expected_ticks.pop_front();
            if (got !== want)
                log_fail("mismatch", want, got);
        endfunction

        function void flush_missing();
            while (expected_ticks.size() != 0)
                log_fail("missing transaction", expected_ticks.pop_front(), 'x);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   snd_idle;
    int   rcv_idle;
    int   results_seen;
    bit   held_off;
    click_scoreboard tracker;

    bdc_sample_if sample_ch ();
    bdc_result_if result_ch ();
    bdc_cfg_if    cfg_ch ();

    button_debounce_click_detector #(.NUM_BUTTONS(3)) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .result  (result_ch),
        .cfg     (cfg_ch)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

    // output side: random stalls, one long hold-off once traffic runs unthrottled
    initial
    begin
        result_ch.ready = 1'b0;
        results_seen    = 0;
        held_off        = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held_off && rcv_idle == 0 && results_seen >= 330)
            begin
                held_off        = 1'b1;
                result_ch.ready = 1'b0;
                repeat (60) @(posedge clk);
            end
            else
            begin
                result_ch.ready = ($urandom_range(0, 99) >= rcv_idle);
                @(posedge clk);
                if (rst_n && result_ch.valid && result_ch.ready)
                begin
                    tracker.check_result('{result_ch.pressed_levels, result_ch.click_events,
                                           result_ch.double_click_events});
                    results_seen++;
                end
            end
        end
    end

    task automatic send_sample(logic [FIELD_W-1:0] raw);
        while ($urandom_range(0, 99) < snd_idle)
        begin
            @(negedge clk);
            sample_ch.valid = 1'b0;
        end
        @(negedge clk);
        sample_ch.valid      = 1'b1;
        sample_ch.raw_levels = raw;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        tracker.note_sample(raw);
    endtask

    task automatic drain();
        int guard;
        @(negedge clk);
        sample_ch.valid = 1'b0;
        guard = 0;
        while (tracker.expected_ticks.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        tracker.write_reg(idx, data);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic configure(int samples_val, int ticks_val);
        write_reg(CFG_DEBOUNCE_SAMPLES, CFG_DATA_W'(samples_val));
        write_reg(CFG_DOUBLE_CLICK_TICKS, CFG_DATA_W'(ticks_val));
    endtask

    // per-button press/release runs with random lengths, bounce noise and stray items
    task automatic run_stream(int n, int hold_hi, int noise_pct);
        logic [FIELD_W-1:0] lvl;
        logic [FIELD_W-1:0] raw;
        int left [FIELD_W];
        lvl = '1;
        for (int b = 0; b < FIELD_W; b++)
            left[b] = $urandom_range(1, hold_hi);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 99) < 5)
                raw = FIELD_W'($urandom_range(0, 7));
            else
                for (int b = 0; b < FIELD_W; b++)
                begin
                    if (left[b] == 0)
                    begin
                        lvl[b]  = ~lvl[b];
                        left[b] = $urandom_range(1, hold_hi);
                    end
                    left[b]--;
                    raw[b] = lvl[b] ^ ($urandom_range(0, 99) < noise_pct);
                end
            send_sample(raw);
        end
        drain();
    endtask

    initial
    begin
        tracker              = new();
        snd_idle             = 22;
        rcv_idle             = 85;
        sample_ch.valid      = 1'b0;
        sample_ch.raw_levels = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_DEBOUNCE_SAMPLES;
        cfg_ch.data          = '0;
        rst_n                = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single click, double click inside the window, click after it expires
        configure(1, 3);
        send_sample(3'b111);
        send_sample(3'b000);
        send_sample(3'b111);
        send_sample(3'b000);
        send_sample(3'b111);
        send_sample(3'b111);
        send_sample(3'b111);
        send_sample(3'b111);
        send_sample(3'b000);
        drain();

        // zero debounce count and zero window: instant response, never a double
        configure(0, 0);
        send_sample(3'b000);
        send_sample(3'b111);
        send_sample(3'b000);
        send_sample(3'b111);
        send_sample(3'b000);
        send_sample(3'b101);
        send_sample(3'b010);
        drain();

        configure(8, 250);
        run_stream(70, 24, 5);
        configure(3, 30);
        run_stream(80, 10, 8);

        snd_idle = 85;
        rcv_idle = 22;
        configure(255, 65535);
        run_stream(60, 60, 3);
        // lower the limit with counters still high
        configure(2, 1);
        run_stream(60, 6, 5);

        snd_idle = 0;
        rcv_idle = 0;
        configure(1, 6);
        run_stream(80, 4, 5);
        configure(5, 65535);
        run_stream(60, 14, 5);
        configure(0, 3);
        run_stream(40, 3, 10);

        tracker.flush_missing();
        if (tracker.fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
